// ===== rtl/esrch_pkg.sv =====
`default_nettype none

package esrch_pkg;

    // Default number of entries in the value store.
    localparam int unsigned DEPTH_DEFAULT = 1024;

    // Width of the reported position; the position is given in its low bits.
    localparam int unsigned INDEX_W = 10;

    // Request codes carried in req_type.
    localparam logic [1:0] REQ_APPEND = 2'd0;
    localparam logic [1:0] REQ_SEARCH = 2'd1;
    localparam logic [1:0] REQ_CLEAR  = 2'd2;

    typedef struct packed {
        logic [1:0]         req_type;
        logic signed [31:0] elem_value;
        logic signed [31:0] search_key;
    } req_word_t;

    typedef struct packed {
        logic               found;
        logic [INDEX_W-1:0] found_index;
    } rsp_word_t;

endpackage

`default_nettype wire

// ===== rtl/exponential_search_engine.sv =====
`default_nettype none

// Exponential search engine.
// Request channel (req_valid, req_stall, req): each word is an append, a search or
// a clear. Appends write the next free entry of the store, in ascending order, and
// are dropped once the store is full; a clear empties the store. Neither returns
// a word. Each search returns exactly one word on the response channel (rsp_valid,
// rsp_stall, rsp) carrying a found flag and the position of the key, which is
// zero when the key is absent or the store is empty.
// Appends and clears leave req_stall low. A search holds req_stall high while a
// small sequencer drives one shared compare unit against the single read port of
// the store: a compare of element zero, one compare per doubling probe, a step that
// sets the range, a midpoint and then a compare per binary step, one more midpoint
// when the range runs empty, and the hand-off of the answer. The engine returns to
// idle as the answer is loaded into the output register. A finished answer sits in
// that register; a new request is taken while it waits, and the engine only holds
// off a second search answer until the receiver drops rsp_stall.
// Reset empties the store (the entries themselves are not cleared) and drops any
// pending response.
module exponential_search_engine
    import esrch_pkg::*;
#(
    parameter int unsigned STORE_DEPTH = DEPTH_DEFAULT
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      req_valid,
    output logic           req_stall,
    input  wire req_word_t req,
    output logic           rsp_valid,
    input  wire logic      rsp_stall,
    output rsp_word_t      rsp
);

    localparam int unsigned AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int unsigned CW = $clog2(STORE_DEPTH + 1);
    // Probe bound may reach just under twice the element count.
    localparam int unsigned BW = CW + 1;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_CMP0 = 7'b0000010,
        S_CMPE = 7'b0000100,
        S_BSET = 7'b0001000,
        S_MID  = 7'b0010000,
        S_CMPB = 7'b0100000,
        S_DONE = 7'b1000000
    } state_t;

    state_t             state_reg, state_next;
    logic [CW-1:0]      count_reg, count_next;
    logic signed [31:0] key_reg, key_next;
    logic [BW-1:0]      bound_reg, bound_next;
    logic [BW-1:0]      lo_reg, lo_next;
    logic [BW-1:0]      hi_reg, hi_next;
    logic [BW-1:0]      mid_reg, mid_next;
    logic               hit_reg, hit_next;
    logic               rsp_valid_reg, rsp_valid_next;
    rsp_word_t          rsp_reg, rsp_next;

    // Value store and its registered read data.
    logic signed [31:0] store_mem [STORE_DEPTH];
    logic signed [31:0] data_reg;
    logic [AW-1:0]      rd_addr;
    logic               wr_en;

    logic [BW-1:0]      count_ext;
    logic [BW-1:0]      n_minus1;
    logic [BW-1:0]      bound_dbl;
    logic [BW-1:0]      mid_calc;
    logic [31:0]        pos_wide;
    logic               val_eq;
    logic               val_lt;

    assign count_ext = BW'(count_reg);
    assign n_minus1  = count_ext - BW'(1);
    assign bound_dbl = bound_reg << 1;
    assign mid_calc  = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign pos_wide  = 32'(mid_reg);

    // The one shared comparator: stored value against the key.
    assign val_eq = (data_reg == key_reg);
    assign val_lt = (data_reg < key_reg);

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        key_next       = key_reg;
        bound_next     = bound_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        mid_next       = mid_reg;
        hit_next       = hit_reg;
        rd_addr        = '0;
        wr_en          = 1'b0;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rsp_next       = rsp_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    case (req.req_type)
                        REQ_APPEND:
                        begin
                            if (count_reg < CW'(STORE_DEPTH))
                            begin
                                wr_en      = 1'b1;
                                count_next = count_reg + CW'(1);
                            end
                        end
                        REQ_SEARCH:
                        begin
                            key_next = req.search_key;
                            if (count_reg == '0)
                            begin
                                hit_next   = 1'b0;
                                mid_next   = '0;
                                state_next = S_DONE;
                            end
                            else
                            begin
                                rd_addr    = '0;
                                state_next = S_CMP0;
                            end
                        end
                        REQ_CLEAR:
                        begin
                            count_next = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_CMP0:
            begin
                if (val_eq)
                begin
                    hit_next   = 1'b1;
                    mid_next   = '0;
                    state_next = S_DONE;
                end
                else
                begin
                    bound_next = BW'(1);
                    if (BW'(1) < count_ext)
                    begin
                        rd_addr    = AW'(1);
                        state_next = S_CMPE;
                    end
                    else
                    begin
                        state_next = S_BSET;
                    end
                end
            end
            S_CMPE:
            begin
                if (!val_lt && !val_eq)
                begin
                    state_next = S_BSET;
                end
                else
                begin
                    bound_next = bound_dbl;
                    if (bound_dbl < count_ext)
                    begin
                        rd_addr    = bound_dbl[AW-1:0];
                        state_next = S_CMPE;
                    end
                    else
                    begin
                        state_next = S_BSET;
                    end
                end
            end
            S_BSET:
            begin
                lo_next    = bound_reg >> 1;
                hi_next    = (bound_reg < n_minus1) ? bound_reg : n_minus1;
                state_next = S_MID;
            end
            S_MID:
            begin
                if (lo_reg > hi_reg)
                begin
                    hit_next   = 1'b0;
                    mid_next   = '0;
                    state_next = S_DONE;
                end
                else
                begin
                    mid_next   = mid_calc;
                    rd_addr    = mid_calc[AW-1:0];
                    state_next = S_CMPB;
                end
            end
            S_CMPB:
            begin
                if (val_eq)
                begin
                    hit_next   = 1'b1;
                    state_next = S_DONE;
                end
                else if (val_lt)
                begin
                    lo_next    = mid_reg + BW'(1);
                    state_next = S_MID;
                end
                else if (mid_reg == lo_reg)
                begin
                    // The upper limit would drop below the lower one.
                    hit_next   = 1'b0;
                    mid_next   = '0;
                    state_next = S_DONE;
                end
                else
                begin
                    hi_next    = mid_reg - BW'(1);
                    state_next = S_MID;
                end
            end
            S_DONE:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_valid_next       = 1'b1;
                    rsp_next.found       = hit_reg;
                    rsp_next.found_index = pos_wide[INDEX_W-1:0];
                    state_next           = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg   <= key_next;
        bound_reg <= bound_next;
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        mid_reg   <= mid_next;
        hit_reg   <= hit_next;
        rsp_reg   <= rsp_next;
    end

    // Single write port at the fill position, single registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_mem[count_reg[AW-1:0]] <= req.elem_value;
        end
        data_reg <= store_mem[rd_addr];
    end

    // The fill count never passes the store depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(STORE_DEPTH))
        else $error("element count beyond store depth");

    // An append to a full store leaves the count alone.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && req_valid && req.req_type == REQ_APPEND
         && count_reg == CW'(STORE_DEPTH)) |=> $stable(count_reg))
        else $error("append to full store changed the count");

    // Doubling probes only touch written entries.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CMPE) |-> (bound_reg < count_ext))
        else $error("doubling probe beyond element count");

    // Binary probes only touch written entries.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CMPB) |-> (mid_reg < count_ext && mid_reg >= lo_reg))
        else $error("binary probe outside the search range");

endmodule

`default_nettype wire
